// ===== hdl/bcrm_pkg.sv =====
// Shared types and codes for the blit clip rectangle mapper.
// No dependencies; the interfaces, the unit, the register file and the testbench use it.
`default_nettype none
package bcrm_pkg;
	localparam int FIELD_W = 16;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int XF_W    = 3;

	// transform register bits
	localparam int XF_FLIP_H = 0;
	localparam int XF_FLIP_V = 1;
	localparam int XF_ROT90  = 2;

	typedef logic [1:0] rect_status_t;
	localparam rect_status_t ST_OK     = 2'd0;
	localparam rect_status_t ST_EMPTY  = 2'd1;
	localparam rect_status_t ST_NO_WIN = 2'd2;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_TRANSFORM = 3'd0;
	localparam reg_idx_t REG_DST_WIN_LT = 3'd1;
	localparam reg_idx_t REG_DST_WIN_RB = 3'd2;
	localparam reg_idx_t REG_SRC_WIN_LT = 3'd3;
	localparam reg_idx_t REG_SRC_WIN_RB = 3'd4;
	localparam reg_idx_t REG_DST_IMG    = 3'd5;
	localparam reg_idx_t REG_SRC_IMG    = 3'd6;

	// register file contents, split into coordinates
	typedef struct packed {
		logic [XF_W-1:0]    xf;
		logic [FIELD_W-1:0] dl, dt, dr, db;
		logic [FIELD_W-1:0] sl, st, sr, sb;
		logic [FIELD_W-1:0] diw, dih;
		logic [FIELD_W-1:0] siw, sih;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hdl/bcrm_if.sv =====
// Channel interfaces: clip rectangle in, mapped rectangle out, register writes.
// Depends on bcrm_pkg.
`default_nettype none
interface bcrm_clip_if;
	logic valid;
	logic ready;
	logic [bcrm_pkg::FIELD_W-1:0] clip_left, clip_top, clip_right, clip_bottom;
	modport source(output valid, clip_left, clip_top, clip_right, clip_bottom, input ready);
	modport sink(input valid, clip_left, clip_top, clip_right, clip_bottom, output ready);
endinterface

interface bcrm_rect_if;
	logic valid;
	logic ready;
	logic [bcrm_pkg::FIELD_W-1:0] out_dst_x, out_dst_y, out_dst_w, out_dst_h;
	logic [bcrm_pkg::FIELD_W-1:0] src_x, src_y, src_w, src_h;
	bcrm_pkg::rect_status_t status;
	modport source(output valid, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
		src_x, src_y, src_w, src_h, status, input ready);
	modport sink(input valid, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
		src_x, src_y, src_w, src_h, status, output ready);
endinterface

interface bcrm_cfg_if;
	logic valid;
	logic ready;
	bcrm_pkg::reg_idx_t index;
	logic [bcrm_pkg::CFG_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/blit_clip_rect_mapper_unit.sv =====
// Blit clip rectangle mapper: clip, rotate, scale and flip one rectangle per item.
// Depends on bcrm_pkg, bcrm_if, bcrm_cfg_regs and bcrm_div.
//
// Usage:
//   cfg  - register writes (index, data); always ready. Write only while idle.
//   clip - one clip rectangle per item (left, top, exclusive right/bottom).
//   rect - one result item per clip item: clipped destination rectangle,
//          mapped source rectangle and status.
// From accept to result valid, an item passes the clip and multiply stages, the 33
// stages of the bit-per-stage dividers at 16 bits, and the output stage.
// Throughput is one item per cycle while rect is not stalled.
// The whole pipeline advances together; when rect is stalled with a result
// held, clip.ready drops and every stage holds, so nothing is lost or repeated.
// Reset clears the valid flags and the configuration registers to zero and empties the pipeline.
`default_nettype none
module blit_clip_rect_mapper_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bcrm_cfg_if.sink   cfg,
	bcrm_clip_if.sink  clip,
	bcrm_rect_if.source rect
);
	import bcrm_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = 2 * CB + 1;

	typedef struct packed {
		logic [CB-1:0] dx, dy, dw, dh;
		rect_status_t  st;
	} side_t;

	cfg_t regs;
	logic en;

	bcrm_cfg_regs u_regs (.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs));

	// coordinates masked to the working width
	logic [CB-1:0] dl, dt, dr, db, sl, st, sr, sb, diw, dih, siw, sih;
	assign dl  = regs.dl[CB-1:0];
	assign dt  = regs.dt[CB-1:0];
	assign dr  = regs.dr[CB-1:0];
	assign db  = regs.db[CB-1:0];
	assign sl  = regs.sl[CB-1:0];
	assign st  = regs.st[CB-1:0];
	assign sr  = regs.sr[CB-1:0];
	assign sb  = regs.sb[CB-1:0];
	assign diw = regs.diw[CB-1:0];
	assign dih = regs.dih[CB-1:0];
	assign siw = regs.siw[CB-1:0];
	assign sih = regs.sih[CB-1:0];

	logic v_s3;
	assign en = !v_s3 || rect.ready;
	assign clip.ready = en;

	// stage 1: clip against image and window
	logic [CB-1:0] li, ti, ri, bi, cl, ct, cr, cb;
	logic          win_bad, empty;
	assign li = clip.clip_left[CB-1:0];
	assign ti = clip.clip_top[CB-1:0];
	assign ri = clip.clip_right[CB-1:0];
	assign bi = clip.clip_bottom[CB-1:0];
	assign cl = (li > dl) ? li : dl;
	assign ct = (ti > dt) ? ti : dt;
	assign cr = (((diw < ri) ? diw : ri) < dr) ? ((diw < ri) ? diw : ri) : dr;
	assign cb = (((dih < bi) ? dih : bi) < db) ? ((dih < bi) ? dih : bi) : db;
	assign win_bad = (dr <= dl) || (db <= dt);
	assign empty   = (cr <= cl) || (cb <= ct);

	logic          v_s1;
	logic [CB-1:0] cl_s1, ct_s1, cr_s1, cb_s1;
	rect_status_t  st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= clip.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s1 <= cl;
			ct_s1 <= ct;
			cr_s1 <= cr;
			cb_s1 <= cb;
			st_s1 <= win_bad ? ST_NO_WIN : (empty ? ST_EMPTY : ST_OK);
		end
	end

	// stage 2: rotate, choose scale factors, multiply
	logic [CB:0]   px, py;
	logic [CB-1:0] pw, ph, ex, ey, swx, swy, mx, my, qdx, qdy;
	logic          rot;
	assign rot = regs.xf[XF_ROT90];
	assign swx = sr - sl;
	assign swy = sb - st;

	always_comb begin
		if (rot) begin
			px = (CB+1)'(ct_s1 - dt) + (CB+1)'(st);
			py = (CB+1)'(dr - cr_s1) + (CB+1)'(sl);
			pw = cb_s1 - ct_s1;
			ph = cr_s1 - cl_s1;
			ex = db - dt;
			ey = dr - dl;
		end else begin
			px = (CB+1)'(cl_s1 - dl) + (CB+1)'(sl);
			py = (CB+1)'(ct_s1 - dt) + (CB+1)'(st);
			pw = cr_s1 - cl_s1;
			ph = cb_s1 - ct_s1;
			ex = dr - dl;
			ey = db - dt;
		end
		// equal extents: pass through as times one over one
		mx  = (swx == ex) ? CB'(1) : swx;
		qdx = (swx == ex) ? CB'(1) : ex;
		my  = (swy == ey) ? CB'(1) : swy;
		qdy = (swy == ey) ? CB'(1) : ey;
	end

	logic          v_s2;
	logic [DW-1:0] nx_s2, nw_s2, ny_s2, nh_s2;
	logic [CB-1:0] dx_s2, dy_s2;
	side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= DW'(px) * DW'(mx);
			nw_s2 <= DW'(pw) * DW'(mx);
			ny_s2 <= DW'(py) * DW'(my);
			nh_s2 <= DW'(ph) * DW'(my);
			dx_s2 <= qdx;
			dy_s2 <= qdy;
			side_s2 <= '{dx: cl_s1, dy: ct_s1, dw: cr_s1 - cl_s1, dh: cb_s1 - ct_s1,
				st: st_s1};
		end
	end

	// division stages
	logic [CB-1:0] qx, qw, qy, qh;
	bcrm_div #(.NUM_W(DW), .DEN_W(CB)) u_div_x (.clk(clk), .en(en), .num(nx_s2),
		.den(dx_s2), .quo(qx));
	bcrm_div #(.NUM_W(DW), .DEN_W(CB)) u_div_w (.clk(clk), .en(en), .num(nw_s2),
		.den(dx_s2), .quo(qw));
	bcrm_div #(.NUM_W(DW), .DEN_W(CB)) u_div_y (.clk(clk), .en(en), .num(ny_s2),
		.den(dy_s2), .quo(qy));
	bcrm_div #(.NUM_W(DW), .DEN_W(CB)) u_div_h (.clk(clk), .en(en), .num(nh_s2),
		.den(dy_s2), .quo(qh));

	// valid and sideband travel alongside the divider stages
	logic  v_sd [DW];
	side_t side_sd [DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DW; i++) v_sd[i] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s2;
			for (int i = 1; i < DW; i++) v_sd[i] <= v_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s2;
			for (int i = 1; i < DW; i++) side_sd[i] <= side_sd[i-1];
		end
	end

	// output stage: flips and status masking
	side_t         sd;
	logic [CB-1:0] fx, fy;
	logic          ok;
	assign sd = side_sd[DW-1];
	assign ok = (sd.st == ST_OK);
	assign fx = regs.xf[XF_FLIP_H] ? CB'(siw - (qx + qw)) : qx;
	assign fy = regs.xf[XF_FLIP_V] ? CB'(sih - (qy + qh)) : qy;

	logic [CB-1:0] ox_s3, oy_s3, ow_s3, oh_s3, sx_s3, sy_s3, sw_s3, sh_s3;
	rect_status_t  st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_sd[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s3 <= (sd.st == ST_NO_WIN) ? '0 : sd.dx;
			oy_s3 <= (sd.st == ST_NO_WIN) ? '0 : sd.dy;
			ow_s3 <= ok ? sd.dw : '0;
			oh_s3 <= ok ? sd.dh : '0;
			sx_s3 <= ok ? fx : '0;
			sy_s3 <= ok ? fy : '0;
			sw_s3 <= ok ? qw : '0;
			sh_s3 <= ok ? qh : '0;
			st_s3 <= sd.st;
		end
	end

	assign rect.valid     = v_s3;
	assign rect.out_dst_x = FIELD_W'(ox_s3);
	assign rect.out_dst_y = FIELD_W'(oy_s3);
	assign rect.out_dst_w = FIELD_W'(ow_s3);
	assign rect.out_dst_h = FIELD_W'(oh_s3);
	assign rect.src_x     = FIELD_W'(sx_s3);
	assign rect.src_y     = FIELD_W'(sy_s3);
	assign rect.src_w     = FIELD_W'(sw_s3);
	assign rect.src_h     = FIELD_W'(sh_s3);
	assign rect.status    = st_s3;
endmodule
`default_nettype wire

// ===== hdl/bcrm_cfg_regs.sv =====
// Configuration register file of the clip rectangle mapper.
// Depends on bcrm_pkg and bcrm_cfg_if.
`default_nettype none
module bcrm_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bcrm_cfg_if.sink     cfg,
	output bcrm_pkg::cfg_t regs
);
	import bcrm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TRANSFORM:  regs_q.xf <= cfg.data[XF_W-1:0];
				REG_DST_WIN_LT: {regs_q.dt, regs_q.dl} <= cfg.data;
				REG_DST_WIN_RB: {regs_q.db, regs_q.dr} <= cfg.data;
				REG_SRC_WIN_LT: {regs_q.st, regs_q.sl} <= cfg.data;
				REG_SRC_WIN_RB: {regs_q.sb, regs_q.sr} <= cfg.data;
				REG_DST_IMG:    {regs_q.dih, regs_q.diw} <= cfg.data;
				REG_SRC_IMG:    {regs_q.sih, regs_q.siw} <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/bcrm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, low quotient bits out.
// No dependencies.
`default_nettype none
module bcrm_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic [DEN_W-1:0]      quo
);
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [DEN_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	assign quo = quo_s[NUM_W-1];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in, q_in, d_in;
		logic [NUM_W-1:0] num_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign q_in   = '0;
			assign d_in   = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign q_in   = quo_s[k-1];
			assign d_in   = den_s[k-1];
		end

		// bring down one dividend bit, subtract if it fits
		assign trial = {rem_in, num_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
				num_s[k] <= {num_in[NUM_W-2:0], 1'b0};
				quo_s[k] <= {q_in[DEN_W-2:0], ge};
				den_s[k] <= d_in;
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_blit_clip_rect_mapper_unit.sv =====
// Self-checking testbench for blit_clip_rect_mapper_unit: directed and random clip
// rectangles under several register settings, predicted in-bench, compared per item.
// Depends on bcrm_pkg and bcrm_if.
`timescale 1ns / 100ps
`default_nettype none
module tb_blit_clip_rect_mapper_unit;
	import bcrm_pkg::*;

	typedef struct packed {
		logic [15:0] l, t, r, b;
	} clip_item_t;

	typedef struct packed {
		logic [15:0] dx, dy, dw, dh, sx, sy, sw, sh;
		rect_status_t st;
	} rect_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bcrm_cfg_if  cfg_ch();
	bcrm_clip_if clip_ch();
	bcrm_rect_if rect_ch();

	blit_clip_rect_mapper_unit #(.COORD_BITS(16)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .clip(clip_ch.sink), .rect(rect_ch.source)
	);

	always #5 clk = ~clk;

	// shadow copy of the register file
	logic [2:0]  m_xf;
	logic [31:0] m_dwlt, m_dwrb, m_swlt, m_swrb, m_dimg, m_simg;

	clip_item_t pending_clips[$];
	rect_item_t expected_rects[$];
	int errors = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 86;
	int hold_off = 0;

	// multiply/divide rule: untouched when extents match or divisor is zero
	function automatic logic [63:0] scaled(logic [63:0] v, logic [31:0] mul, logic [31:0] dv);
		if (mul == dv || dv == 0) return v;
		return (v * mul) / dv;
	endfunction

	function automatic rect_item_t map_rect(clip_item_t c);
		rect_item_t o;
		logic [31:0] dl, dt, dr, db, sl, st, sr, sb, cl, ct, cr, cb, ew, eh, swx, swy;
		logic [63:0] x, y, w, h;
		o = '0;
		dl = 32'(m_dwlt[15:0]); dt = 32'(m_dwlt[31:16]);
		dr = 32'(m_dwrb[15:0]); db = 32'(m_dwrb[31:16]);
		sl = 32'(m_swlt[15:0]); st = 32'(m_swlt[31:16]);
		sr = 32'(m_swrb[15:0]); sb = 32'(m_swrb[31:16]);
		swx = (sr - sl) & 32'hffff;
		swy = (sb - st) & 32'hffff;
		if (dr <= dl || db <= dt) begin
			o.st = ST_NO_WIN;
			return o;
		end
		cl = (c.l > dl) ? 32'(c.l) : dl;
		ct = (c.t > dt) ? 32'(c.t) : dt;
		cr = 32'((c.r < m_dimg[15:0]) ? c.r : m_dimg[15:0]);
		if (dr < cr) cr = dr;
		cb = 32'((c.b < m_dimg[31:16]) ? c.b : m_dimg[31:16]);
		if (db < cb) cb = db;
		o.dx = cl[15:0];
		o.dy = ct[15:0];
		if (cr <= cl || cb <= ct) begin
			o.st = ST_EMPTY;
			return o;
		end
		o.dw = 16'(cr - cl);
		o.dh = 16'(cb - ct);
		if (m_xf[XF_ROT90]) begin
			x = 64'((ct - dt) + st); y = 64'((dr - cr) + sl);
			w = 64'(cb - ct); h = 64'(cr - cl); ew = db - dt; eh = dr - dl;
		end else begin
			x = 64'((cl - dl) + sl); y = 64'((ct - dt) + st);
			w = 64'(cr - cl); h = 64'(cb - ct); ew = dr - dl; eh = db - dt;
		end
		x = scaled(x, swx, ew);
		w = scaled(w, swx, ew);
		y = scaled(y, swy, eh);
		h = scaled(h, swy, eh);
		if (m_xf[XF_FLIP_V]) y = 64'(m_simg[31:16]) - (y + h);
		if (m_xf[XF_FLIP_H]) x = 64'(m_simg[15:0]) - (x + w);
		o.sx = x[15:0]; o.sy = y[15:0]; o.sw = w[15:0]; o.sh = h[15:0];
		o.st = ST_OK;
		return o;
	endfunction

	// clip item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_ch.valid <= 1'b0;
			{clip_ch.clip_left, clip_ch.clip_top, clip_ch.clip_right, clip_ch.clip_bottom} <= '0;
		end else begin
			if (clip_ch.valid && clip_ch.ready) begin
				expected_rects.push_back(map_rect({clip_ch.clip_left, clip_ch.clip_top,
					clip_ch.clip_right, clip_ch.clip_bottom}));
				void'(pending_clips.pop_front());
			end
			if ((!clip_ch.valid || clip_ch.ready) || !clip_ch.valid) begin
				if (clip_ch.valid && !clip_ch.ready) begin
					// hold the offered item
				end else if (pending_clips.size() > (clip_ch.valid && clip_ch.ready ? 0 : 0)
					&& pending_clips.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					clip_ch.valid <= 1'b1;
					{clip_ch.clip_left, clip_ch.clip_top, clip_ch.clip_right,
						clip_ch.clip_bottom} <= pending_clips[0];
				end else begin
					clip_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rect_ch.ready <= 1'b0;
		end else begin
			rect_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		rect_item_t got, want;
		if (arst_n && rect_ch.valid && rect_ch.ready) begin
			got = {rect_ch.out_dst_x, rect_ch.out_dst_y, rect_ch.out_dst_w, rect_ch.out_dst_h,
				rect_ch.src_x, rect_ch.src_y, rect_ch.src_w, rect_ch.src_h, rect_ch.status};
			if (expected_rects.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item %h", got);
			end else begin
				want = expected_rects.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// one write; valid stays high so writes can follow back to back
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_TRANSFORM:  m_xf = val[2:0];
			REG_DST_WIN_LT: m_dwlt = val;
			REG_DST_WIN_RB: m_dwrb = val;
			REG_SRC_WIN_LT: m_swlt = val;
			REG_SRC_WIN_RB: m_swrb = val;
			REG_DST_IMG:    m_dimg = val;
			REG_SRC_IMG:    m_simg = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_clips.size() != 0 || clip_ch.valid || expected_rects.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_setting(logic [2:0] xf, logic [31:0] dwlt, logic [31:0] dwrb,
		logic [31:0] swlt, logic [31:0] swrb, logic [31:0] dimg, logic [31:0] simg);
		wait_drained();
		write_reg(REG_TRANSFORM, {29'd0, xf});
		write_reg(REG_DST_WIN_LT, dwlt);
		write_reg(REG_DST_WIN_RB, dwrb);
		write_reg(REG_SRC_WIN_LT, swlt);
		write_reg(REG_SRC_WIN_RB, swrb);
		write_reg(REG_DST_IMG, dimg);
		write_reg(REG_SRC_IMG, simg);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(300));
		endcase
	endfunction

	function automatic logic [31:0] rnd_pair();
		return {rnd_coord(), rnd_coord()};
	endfunction

	task automatic queue_random(int n);
		clip_item_t c;
		repeat (n) begin
			c.l = rnd_coord(); c.t = rnd_coord();
			// mostly well-formed rectangles
			if ($urandom_range(9) < 8) begin
				c.r = c.l + 16'($urandom_range(1, 200));
				c.b = c.t + 16'($urandom_range(1, 200));
			end else begin
				c.r = rnd_coord(); c.b = rnd_coord();
			end
			pending_clips.push_back(c);
		end
	endtask

	initial begin
		clip_item_t c;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		m_xf = '0; m_dwlt = '0; m_dwrb = '0; m_swlt = '0; m_swrb = '0; m_dimg = '0; m_simg = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window is degenerate
		pending_clips.push_back('{16'd0, 16'd0, 16'd10, 16'd10});
		// identity-sized windows, then directed corner rectangles
		load_setting(3'd0, 32'h0000_0000, 32'h0100_0100, 32'h0000_0000, 32'h0100_0100,
			32'h0200_0200, 32'h0200_0200);
		pending_clips.push_back('{16'd0, 16'd0, 16'hffff, 16'hffff});
		pending_clips.push_back('{16'hffff, 16'hffff, 16'h0000, 16'h0000});
		pending_clips.push_back('{16'd10, 16'd20, 16'd10, 16'd40});
		pending_clips.push_back('{16'd5, 16'd6, 16'd50, 16'd70});
		pending_clips.push_back('{16'h0100, 16'd0, 16'h0200, 16'd5});
		// scaling, rotation and flips
		load_setting(3'd7, 32'h0010_0008, 32'h0090_0108, 32'h0003_0002, 32'h0300_0180,
			32'hffff_ffff, 32'h0400_0300);
		pending_clips.push_back('{16'd0, 16'd0, 16'hffff, 16'hffff});
		pending_clips.push_back('{16'd20, 16'd30, 16'd40, 16'd50});
		pending_clips.push_back('{16'd300, 16'd300, 16'd400, 16'd400});
		// reversed source window, zero height destination window
		load_setting(3'd1, 32'h0000_0000, 32'h0040_0040, 32'h0040_0040, 32'h0000_0000,
			32'h0080_0080, 32'hffff_ffff);
		pending_clips.push_back('{16'd1, 16'd2, 16'd30, 16'd31});
		load_setting(3'd2, 32'h0020_0000, 32'h0020_0040, 32'h0, 32'h0040_0040,
			32'h0080_0080, 32'h0);
		pending_clips.push_back('{16'd1, 16'd2, 16'd30, 16'd31});

		// random phases over random and extreme settings
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 86; recv_idle_pct = 16;
			end else if (ph == 8) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			if (ph == 0)
				load_setting(3'd0, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
					32'hffff_ffff, 32'hffff_ffff);
			else if (ph == 11)
				load_setting(3'd7, 32'hfffe_fffe, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
					32'hffff_ffff, 32'h0);
			else begin
				c.l = 16'($urandom_range(60)); c.t = 16'($urandom_range(60));
				load_setting(3'($urandom), {c.t, c.l}, {c.t + 16'($urandom_range(1, 250)),
					c.l + 16'($urandom_range(1, 250))}, rnd_pair(),
					$urandom_range(9) < 2 ? rnd_pair() :
						{16'($urandom_range(400)), 16'($urandom_range(400))},
					$urandom_range(3) == 0 ? rnd_pair() : 32'h0120_0120, rnd_pair());
			end
			if (ph == 9) hold_off = 400;
			queue_random(120);
		end
		wait_drained();
		if (errors == 0)
			$display("blit_clip_rect_mapper_unit regression: pass");
		else
			$display("blit_clip_rect_mapper_unit regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("blit_clip_rect_mapper_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
